/* sv/trml_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trml_pkg: shared definitions of the traffic rate meter and limiter
// Widths, event kind codes, counter slots and the history row layout.
// ----------------------------------------------------------------------------
package trml_pkg;

    localparam int HISTORY_DEPTH = 1024;
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    localparam int NUM_CTR = 6;
    localparam int CTR_W = 64;
    localparam int RATE_W = 32;
    // A dividend is a 64-bit delta times 1000.
    localparam int NUM_W = CTR_W + 10;

    localparam logic [2:0] CTR_APP_IN      = 3'd0;
    localparam logic [2:0] CTR_APP_IN_ALL  = 3'd1;
    localparam logic [2:0] CTR_APP_OUT     = 3'd2;
    localparam logic [2:0] CTR_APP_OUT_ALL = 3'd3;
    localparam logic [2:0] CTR_NET_IN      = 3'd4;
    localparam logic [2:0] CTR_NET_OUT     = 3'd5;

    localparam logic [3:0] KIND_IN_PAY   = 4'd0;
    localparam logic [3:0] KIND_OUT_PAY  = 4'd1;
    localparam logic [3:0] KIND_IN_TCP   = 4'd2;
    localparam logic [3:0] KIND_IN_UDP   = 4'd3;
    localparam logic [3:0] KIND_OUT_TCP  = 4'd4;
    localparam logic [3:0] KIND_OUT_UDP  = 4'd5;
    localparam logic [3:0] KIND_OUT_RAW  = 4'd6;
    localparam logic [3:0] KIND_SETUP    = 4'd7;
    localparam logic [3:0] KIND_SAMPLE   = 4'd8;
    localparam logic [3:0] KIND_TICK     = 4'd9;

    localparam logic [2:0] REG_MAX_DL     = 3'd0;
    localparam logic [2:0] REG_WINDOW     = 3'd1;
    localparam logic [2:0] REG_RATE_SAMP  = 3'd2;
    localparam logic [2:0] REG_ACCEPT_SRC = 3'd3;
    localparam logic [2:0] REG_FULL_CTRL  = 3'd4;

    localparam logic [CTR_W-1:0] HDR_TCP = 64'd40;
    localparam logic [CTR_W-1:0] HDR_UDP = 64'd28;
    localparam logic [NUM_W-1:0] MS_PER_S = NUM_W'(1000);
    localparam logic [31:0] LIMIT_FLOOR = 32'd1024;
    localparam logic [31:0] DYN_LOW = 32'd4096;
    localparam logic [31:0] DYN_HIGH = 32'd11264;
    localparam logic [CNT_W-1:0] LIMIT_BACK = CNT_W'(10);
    localparam logic [31:0] WINDOW_RESET = 32'd60000;
    localparam logic [9:0] RATE_SAMP_RESET = 10'd10;

    typedef struct packed {
        logic [31:0] stamp;
        logic [NUM_CTR-1:0][CTR_W-1:0] cnt;
    } row_t;

endpackage

/* sv/traffic_rate_meter_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_rate_meter_limiter: byte counters, snapshot history and rate limits
// Accounting events and adapter samples are taken while the block is idle, so
// one such request can be accepted every cycle while no tick is in progress.
// A tick pushes a snapshot, trims the history to the window, then computes six
// rates and up to two limits on the shared 74-step divider; the input stalls
// until the result goes into the output slot. Reset is asynchronous, active
// low, clears counters, history pointers and the output valid flag, and sets
// the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module traffic_rate_meter_limiter
    import trml_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Input request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  kind,
    input  logic [31:0] octets,
    input  logic [31:0] time_ms,
    input  logic        adapter_ok,
    input  logic [31:0] adapter_in_octets,
    input  logic [31:0] adapter_out_octets,
    // Result request channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] app_in_rate,
    output logic [31:0] app_in_all_rate,
    output logic [31:0] app_out_rate,
    output logic [31:0] app_out_all_rate,
    output logic [31:0] net_in_rate,
    output logic [31:0] net_out_rate,
    output logic [31:0] download_limit_bps,
    output logic [31:0] forced_limit_bps,
    output logic        limits_done
);

    // The sequencer walks a tick through push, trim, rates and limits.
    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_PUSH     = 11'b00000000010,
        S_TRIM_RD  = 11'b00000000100,
        S_TRIM_CHK = 11'b00000001000,
        S_RATE_RD  = 11'b00000010000,
        S_RATE_LAT = 11'b00000100000,
        S_MUL      = 11'b00001000000,
        S_DIV      = 11'b00010000000,
        S_LIM_RD   = 11'b00100000000,
        S_LIM_LAT  = 11'b01000000000,
        S_FIN      = 11'b10000000000
    } state_t;

    localparam logic [2:0] SEL_FORCED = 3'd6;
    localparam logic [2:0] SEL_DYN    = 3'd7;
    localparam logic [6:0] DIV_LAST   = 7'(NUM_W - 1);

    state_t state_reg, state_next;

    // Configuration registers
    logic [31:0] max_dl_reg, max_dl_next;
    logic [31:0] window_reg, window_next;
    logic [9:0]  rsamp_reg, rsamp_next;
    logic        asl_reg, asl_next;
    logic        fc_reg, fc_next;

    // Running counters and adapter history
    logic [NUM_CTR-1:0][CTR_W-1:0] cnt_reg, cnt_next;
    logic [31:0] last_ain_reg, last_ain_next;
    logic [31:0] last_aout_reg, last_aout_next;

    // History ring pointers
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Tick working registers
    logic [31:0]      tick_time_reg, tick_time_next;
    logic [31:0]      span_reg, span_next;
    row_t             old_reg, old_next;
    logic [2:0]       sel_reg, sel_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic             ovf_reg, ovf_next;
    logic [6:0]       step_reg, step_next;
    logic [NUM_CTR-1:0][RATE_W-1:0] rate_reg, rate_next;
    logic [31:0]      dl_reg, dl_next;
    logic [31:0]      forced_reg, forced_next;
    logic             done_reg, done_next;

    // Output slot
    logic        out_valid_reg, out_valid_next;
    logic [NUM_CTR-1:0][RATE_W-1:0] out_rate_reg, out_rate_next;
    logic [31:0] out_dl_reg, out_dl_next;
    logic [31:0] out_forced_reg, out_forced_next;
    logic        out_done_reg, out_done_next;

    // History RAM
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    row_t             ram_wdata, ram_rdata;

    // Divider step and helpers
    logic             in_acc, out_acc;
    logic [32:0]      trial;
    logic             trial_ge;
    logic [32:0]      trial_sub;
    logic [31:0]      quo_step;
    logic             ovf_step;
    logic [31:0]      rate_val;
    logic [2:0]       ctr_sel;
    logic [CTR_W-1:0] delta;
    logic [NUM_W-1:0] delta_ext;
    logic [31:0]      new_span;
    logic [CNT_W-1:0] back;
    logic [33:0]      forced_cand;
    logic [33:0]      dyn_cand;

    function automatic logic [IDX_W-1:0] slot_back(input logic [IDX_W-1:0] hd,
                                                   input logic [CNT_W-1:0] bk);
        logic [CNT_W:0] sum;
        begin
            sum = (CNT_W + 1)'(hd);
            if ((CNT_W + 1)'(bk) > sum)
            begin
                sum = sum + (CNT_W + 1)'(HISTORY_DEPTH);
            end
            sum = sum - (CNT_W + 1)'(bk);
            return sum[IDX_W-1:0];
        end
    endfunction

    trml_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;

    // One restoring division step: the dividend shifts in one bit a cycle.
    // A quotient bit pushed past bit 31 means the rate saturates.
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge = (trial >= {1'b0, span_reg});
    assign trial_sub = trial - {1'b0, span_reg};
    assign quo_step = {quo_reg[30:0], trial_ge};
    assign ovf_step = ovf_reg | quo_reg[31];
    assign rate_val = ovf_step ? '1 : quo_step;

    // The two limit passes use the outbound payload and overall counters.
    always_comb
    begin
        if (sel_reg == SEL_FORCED)
        begin
            ctr_sel = CTR_APP_OUT;
        end
        else if (sel_reg == SEL_DYN)
        begin
            ctr_sel = CTR_APP_OUT_ALL;
        end
        else
        begin
            ctr_sel = sel_reg;
        end
    end

    assign delta = cnt_reg[ctr_sel] - old_reg.cnt[ctr_sel];
    assign delta_ext = {10'b0, delta};
    assign new_span = tick_time_reg - ram_rdata.stamp;
    assign back = (CNT_W'(rsamp_reg) < count_reg) ? CNT_W'(rsamp_reg)
                                                  : count_reg - CNT_W'(1);
    assign forced_cand = {rate_val, 2'b00};
    assign dyn_cand = (rate_val < DYN_LOW) ? 34'(rate_val) * 34'd3
                                           : {rate_val, 2'b00};

    always_comb
    begin
        state_next = state_reg;
        max_dl_next = max_dl_reg;
        window_next = window_reg;
        rsamp_next = rsamp_reg;
        asl_next = asl_reg;
        fc_next = fc_reg;
        cnt_next = cnt_reg;
        last_ain_next = last_ain_reg;
        last_aout_next = last_aout_reg;
        head_next = head_reg;
        count_next = count_reg;
        tick_time_next = tick_time_reg;
        span_next = span_reg;
        old_next = old_reg;
        sel_next = sel_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        ovf_next = ovf_reg;
        step_next = step_reg;
        rate_next = rate_reg;
        dl_next = dl_reg;
        forced_next = forced_reg;
        done_next = done_reg;
        out_valid_next = out_valid_reg && !out_acc;
        out_rate_next = out_rate_reg;
        out_dl_next = out_dl_reg;
        out_forced_next = out_forced_reg;
        out_done_next = out_done_reg;
        ram_we = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = '0;
        ram_re = 1'b0;
        ram_raddr = head_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_DL:     max_dl_next = cfg_wdata;
                REG_WINDOW:     window_next = cfg_wdata;
                REG_RATE_SAMP:  rsamp_next = cfg_wdata[9:0];
                REG_ACCEPT_SRC: asl_next = cfg_wdata[0];
                REG_FULL_CTRL:  fc_next = cfg_wdata[0];
                default:        ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind) inside
                        KIND_IN_PAY:
                            cnt_next[CTR_APP_IN] = cnt_reg[CTR_APP_IN] + CTR_W'(octets);
                        KIND_OUT_PAY:
                            cnt_next[CTR_APP_OUT] = cnt_reg[CTR_APP_OUT] + CTR_W'(octets);
                        KIND_IN_TCP:
                            cnt_next[CTR_APP_IN_ALL] = cnt_reg[CTR_APP_IN_ALL]
                                                       + CTR_W'(octets) + HDR_TCP;
                        KIND_IN_UDP:
                            cnt_next[CTR_APP_IN_ALL] = cnt_reg[CTR_APP_IN_ALL]
                                                       + CTR_W'(octets) + HDR_UDP;
                        KIND_OUT_TCP:
                            cnt_next[CTR_APP_OUT_ALL] = cnt_reg[CTR_APP_OUT_ALL]
                                                        + CTR_W'(octets) + HDR_TCP;
                        KIND_OUT_UDP:
                            cnt_next[CTR_APP_OUT_ALL] = cnt_reg[CTR_APP_OUT_ALL]
                                                        + CTR_W'(octets) + HDR_UDP;
                        KIND_OUT_RAW:
                            cnt_next[CTR_APP_OUT_ALL] = cnt_reg[CTR_APP_OUT_ALL]
                                                        + CTR_W'(octets);
                        KIND_SETUP:
                        begin
                            cnt_next[CTR_APP_IN_ALL] = cnt_reg[CTR_APP_IN_ALL] + HDR_TCP;
                            cnt_next[CTR_APP_OUT_ALL] = cnt_reg[CTR_APP_OUT_ALL] + HDR_TCP;
                        end
                        KIND_SAMPLE, KIND_TICK:
                        begin
                            // Adapter deltas count only when neither counter
                            // went backward; the last values follow anyway.
                            if (adapter_ok && (fc_reg || kind == KIND_TICK))
                            begin
                                if (adapter_in_octets >= last_ain_reg &&
                                    adapter_out_octets >= last_aout_reg)
                                begin
                                    cnt_next[CTR_NET_IN] = cnt_reg[CTR_NET_IN]
                                        + CTR_W'(adapter_in_octets - last_ain_reg);
                                    cnt_next[CTR_NET_OUT] = cnt_reg[CTR_NET_OUT]
                                        + CTR_W'(adapter_out_octets - last_aout_reg);
                                end
                                last_ain_next = adapter_in_octets;
                                last_aout_next = adapter_out_octets;
                            end
                            if (kind == KIND_TICK)
                            begin
                                tick_time_next = time_ms;
                                state_next = S_PUSH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_PUSH:
            begin
                if (count_reg != '0)
                begin
                    head_next = (head_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : head_reg + IDX_W'(1);
                end
                if (count_reg < CNT_W'(HISTORY_DEPTH))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                ram_we = 1'b1;
                ram_waddr = head_next;
                ram_wdata.stamp = tick_time_reg;
                ram_wdata.cnt = cnt_reg;
                state_next = S_TRIM_RD;
            end

            S_TRIM_RD:
            begin
                if (count_reg > CNT_W'(1))
                begin
                    ram_re = 1'b1;
                    ram_raddr = slot_back(head_reg, count_reg - CNT_W'(1));
                    state_next = S_TRIM_CHK;
                end
                else
                begin
                    state_next = S_RATE_RD;
                end
            end

            S_TRIM_CHK:
            begin
                // Drop the oldest snapshot while it is older than the window.
                if (new_span > window_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_TRIM_RD;
                end
                else
                begin
                    state_next = S_RATE_RD;
                end
            end

            S_RATE_RD:
            begin
                rate_next = '0;
                if (count_reg >= CNT_W'(2) && rsamp_reg != '0)
                begin
                    ram_re = 1'b1;
                    ram_raddr = slot_back(head_reg, back);
                    state_next = S_RATE_LAT;
                end
                else
                begin
                    state_next = S_LIM_RD;
                end
            end

            S_RATE_LAT:
            begin
                old_next = ram_rdata;
                span_next = new_span;
                sel_next = '0;
                state_next = (new_span == '0) ? S_LIM_RD : S_MUL;
            end

            S_MUL:
            begin
                // Times 1000 as 1024 - 32 + 8, by shifts and adds.
                num_next = (delta_ext << 10) - (delta_ext << 5) + (delta_ext << 3);
                rem_next = '0;
                quo_next = '0;
                ovf_next = 1'b0;
                step_next = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                rem_next = trial_ge ? trial_sub[31:0] : trial[31:0];
                quo_next = quo_step;
                ovf_next = ovf_step;
                step_next = step_reg + 7'd1;
                if (step_reg == DIV_LAST)
                begin
                    if (sel_reg == SEL_FORCED)
                    begin
                        if (forced_cand < 34'(forced_reg))
                        begin
                            forced_next = forced_cand[31:0];
                        end
                        else
                        begin
                            forced_next = forced_reg;
                        end
                        if (forced_next < LIMIT_FLOOR)
                        begin
                            forced_next = LIMIT_FLOOR;
                        end
                        sel_next = SEL_DYN;
                        state_next = fc_reg ? S_MUL : S_FIN;
                    end
                    else if (sel_reg == SEL_DYN)
                    begin
                        if (rate_val < DYN_HIGH && dyn_cand < 34'(dl_reg))
                        begin
                            dl_next = dyn_cand[31:0];
                        end
                        if (dl_next < LIMIT_FLOOR)
                        begin
                            dl_next = LIMIT_FLOOR;
                        end
                        state_next = S_FIN;
                    end
                    else
                    begin
                        rate_next[sel_reg] = rate_val;
                        sel_next = sel_reg + 3'd1;
                        state_next = (sel_reg == 3'(NUM_CTR - 1)) ? S_LIM_RD : S_MUL;
                    end
                end
            end

            S_LIM_RD:
            begin
                dl_next = max_dl_reg;
                forced_next = max_dl_reg;
                done_next = 1'b1;
                if (count_reg > LIMIT_BACK)
                begin
                    ram_re = 1'b1;
                    ram_raddr = slot_back(head_reg, LIMIT_BACK);
                    state_next = S_LIM_LAT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_LIM_LAT:
            begin
                old_next = ram_rdata;
                span_next = new_span;
                state_next = S_FIN;
                if (!asl_reg || fc_reg)
                begin
                    if (new_span == '0)
                    begin
                        done_next = 1'b0;
                    end
                    else
                    begin
                        sel_next = asl_reg ? SEL_DYN : SEL_FORCED;
                        state_next = S_MUL;
                    end
                end
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next = rate_reg;
                    out_dl_next = dl_reg;
                    out_forced_next = forced_reg;
                    out_done_next = done_reg;
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            max_dl_reg <= '0;
            window_reg <= WINDOW_RESET;
            rsamp_reg <= RATE_SAMP_RESET;
            asl_reg <= 1'b0;
            fc_reg <= 1'b0;
            cnt_reg <= '0;
            last_ain_reg <= '0;
            last_aout_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            max_dl_reg <= max_dl_next;
            window_reg <= window_next;
            rsamp_reg <= rsamp_next;
            asl_reg <= asl_next;
            fc_reg <= fc_next;
            cnt_reg <= cnt_next;
            last_ain_reg <= last_ain_next;
            last_aout_reg <= last_aout_next;
            head_reg <= head_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        tick_time_reg <= tick_time_next;
        span_reg <= span_next;
        old_reg <= old_next;
        sel_reg <= sel_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        step_reg <= step_next;
        rate_reg <= rate_next;
        dl_reg <= dl_next;
        forced_reg <= forced_next;
        done_reg <= done_next;
        out_rate_reg <= out_rate_next;
        out_dl_reg <= out_dl_next;
        out_forced_reg <= out_forced_next;
        out_done_reg <= out_done_next;
    end

    assign out_valid = out_valid_reg;
    assign app_in_rate = out_rate_reg[CTR_APP_IN];
    assign app_in_all_rate = out_rate_reg[CTR_APP_IN_ALL];
    assign app_out_rate = out_rate_reg[CTR_APP_OUT];
    assign app_out_all_rate = out_rate_reg[CTR_APP_OUT_ALL];
    assign net_in_rate = out_rate_reg[CTR_NET_IN];
    assign net_out_rate = out_rate_reg[CTR_NET_OUT];
    assign download_limit_bps = out_dl_reg;
    assign forced_limit_bps = out_forced_reg;
    assign limits_done = out_done_reg;

endmodule

/* sv/trml_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trml_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module trml_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/trml_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trml_checker: port-level checks of the traffic rate meter and limiter
// Watches the request channels and the limit fields of each result.
// ----------------------------------------------------------------------------
module trml_checker
    import trml_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [3:0]  kind,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] download_limit_bps,
    input logic [31:0] forced_limit_bps,
    input logic        limits_done
);

    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A waiting result keeps its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(download_limit_bps))
        else $error("stalled result changed");

    // An accepted tick keeps the block busy for its computation.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && kind == KIND_TICK |=> in_stall)
        else $error("tick did not start a computation");

    // A stopped limit computation leaves both limits at the user ceiling.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !limits_done |-> download_limit_bps == forced_limit_bps)
        else $error("limits differ although computation stopped");

endmodule

bind traffic_rate_meter_limiter trml_checker u_trml_checker (.*);

/* bench/tb_traffic_rate_meter_limiter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_traffic_rate_meter_limiter: self-checking bench of the rate meter
// A queue of pending requests feeds a bursty driver. A predictor mirrors the
// byte counters, the adapter deltas, the snapshot history and the rate and
// limit arithmetic. A monitor checks every report against it. Several
// register settings are visited, the extremes among them.
// ----------------------------------------------------------------------------
module tb_traffic_rate_meter_limiter;
    import trml_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    // A quiet stretch after each phase before the registers change.
    localparam int SETTLE_CYCLES = 800;
    localparam int HOLD_CYCLES = 3000;
    localparam int NUM_FIELDS = 9;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] octets;
        logic [31:0] time_ms;
        logic        ok;
        logic [31:0] ain;
        logic [31:0] aout;
    } request_t;

    // Fields 0..5 are the rates, 6 and 7 the limits, 8 the done flag.
    typedef logic [NUM_FIELDS-1:0][31:0] report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [3:0]  kind = '0;
    logic [31:0] octets = '0;
    logic [31:0] time_ms = '0;
    logic        adapter_ok = 1'b0;
    logic [31:0] adapter_in_octets = '0;
    logic [31:0] adapter_out_octets = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    report_t     seen;

    traffic_rate_meter_limiter i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .kind               (kind),
        .octets             (octets),
        .time_ms            (time_ms),
        .adapter_ok         (adapter_ok),
        .adapter_in_octets  (adapter_in_octets),
        .adapter_out_octets (adapter_out_octets),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .app_in_rate        (seen[0]),
        .app_in_all_rate    (seen[1]),
        .app_out_rate       (seen[2]),
        .app_out_all_rate   (seen[3]),
        .net_in_rate        (seen[4]),
        .net_out_rate       (seen[5]),
        .download_limit_bps (seen[6]),
        .forced_limit_bps   (seen[7]),
        .limits_done        (seen[8][0])
    );
    assign seen[8][31:1] = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a mirror of the block's registers, counters and history.
    // ------------------------------------------------------------------------
    logic [31:0] m_max_dl = '0;
    logic [31:0] m_window = WINDOW_RESET;
    logic [9:0]  m_rate_samples = 10'd10;
    logic        m_accept_src = 1'b0;
    logic        m_full_ctrl = 1'b0;

    logic [63:0] byte_count [6] = '{default: '0};
    logic [31:0] last_net_in = '0;
    logic [31:0] last_net_out = '0;
    logic [31:0] snap_time [HISTORY_DEPTH];
    logic [63:0] snap_count [HISTORY_DEPTH][6];
    int          snap_head = 0;
    int          snap_fill = 0;

    request_t pending_reqs [$];
    report_t  expected_reports [$];
    int n_pushed = 0;
    int n_taken = 0;
    int n_ticks = 0;
    int n_reports = 0;
    int n_mismatch = 0;
    int cycles = 0;
    int hold_req = 0;

    // Generator state: the running clock and the adapter's cumulative counters.
    logic [31:0] gen_time = '0;
    logic [31:0] gen_ain = '0;
    logic [31:0] gen_aout = '0;

    string field_name [NUM_FIELDS] = '{"app_in_rate", "app_in_all_rate", "app_out_rate",
        "app_out_all_rate", "net_in_rate", "net_out_rate", "download_limit_bps",
        "forced_limit_bps", "limits_done"};

    function automatic int slot_back(int back);
        return (snap_head + HISTORY_DEPTH - (back % HISTORY_DEPTH)) % HISTORY_DEPTH;
    endfunction

    // Bytes per second from a byte delta over a span in milliseconds, saturated.
    function automatic logic [31:0] per_second(logic [63:0] delta, logic [31:0] span);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] v;
        q = delta / span;
        r = delta % span;
        if (q >= 64'd4294968)
            return '1;
        v = q * 1000 + (r * 1000) / span;
        return (v > 64'hFFFF_FFFF) ? '1 : v[31:0];
    endfunction

    // Adapter deltas count only when neither cumulative counter went down.
    task automatic adapter_sample(logic [31:0] ain, logic [31:0] aout);
        if (ain >= last_net_in && aout >= last_net_out)
        begin
            byte_count[CTR_NET_IN]  += 64'(ain - last_net_in);
            byte_count[CTR_NET_OUT] += 64'(aout - last_net_out);
        end
        last_net_in = ain;
        last_net_out = aout;
    endtask

    task automatic predict_tick(request_t q);
        report_t     rep;
        int          o;
        int          back;
        logic [31:0] span;
        logic [63:0] c;
        logic [31:0] r;
        logic [31:0] dl;
        logic [31:0] forced;
        logic        done;

        if (q.ok)
            adapter_sample(q.ain, q.aout);
        if (snap_fill > 0)
            snap_head = (snap_head + 1) % HISTORY_DEPTH;
        if (snap_fill < HISTORY_DEPTH)
            snap_fill++;
        snap_time[snap_head] = q.time_ms;
        for (int i = 0; i < 6; i++)
            snap_count[snap_head][i] = byte_count[i];
        // Trim the oldest snapshots that fall outside the window.
        while (snap_fill > 1 &&
               32'(snap_time[snap_head] - snap_time[slot_back(snap_fill - 1)]) > m_window)
            snap_fill--;

        rep = '0;
        if (snap_fill >= 2 && m_rate_samples >= 1)
        begin
            back = (m_rate_samples < snap_fill) ? int'(m_rate_samples) : snap_fill - 1;
            o = slot_back(back);
            span = snap_time[snap_head] - snap_time[o];
            if (span != 0)
                for (int i = 0; i < 6; i++)
                    rep[i] = per_second(snap_count[snap_head][i] - snap_count[o][i], span);
        end

        dl = m_max_dl;
        forced = m_max_dl;
        done = 1'b1;
        if (snap_fill > 10)
        begin
            o = slot_back(10);
            span = snap_time[snap_head] - snap_time[o];
            if (!m_accept_src)
            begin
                if (span == 0)
                    done = 1'b0;
                else
                begin
                    c = 4 * 64'(per_second(snap_count[snap_head][CTR_APP_OUT]
                                           - snap_count[o][CTR_APP_OUT], span));
                    if (c < 64'(forced))
                        forced = c[31:0];
                    if (forced < LIMIT_FLOOR)
                        forced = LIMIT_FLOOR;
                end
            end
            if (done && m_full_ctrl)
            begin
                if (span == 0)
                    done = 1'b0;
                else
                begin
                    r = per_second(snap_count[snap_head][CTR_APP_OUT_ALL]
                                   - snap_count[o][CTR_APP_OUT_ALL], span);
                    if (r < DYN_LOW)
                    begin
                        if (3 * r < dl)
                            dl = 3 * r;
                    end
                    else if (r < DYN_HIGH)
                    begin
                        if (4 * r < dl)
                            dl = 4 * r;
                    end
                    if (dl < LIMIT_FLOOR)
                        dl = LIMIT_FLOOR;
                end
            end
        end
        rep[6] = dl;
        rep[7] = forced;
        rep[8] = 32'(done);
        expected_reports.push_back(rep);
    endtask

    task automatic predict_request(request_t q);
        case (q.kind)
            KIND_IN_PAY:  byte_count[CTR_APP_IN]      += 64'(q.octets);
            KIND_OUT_PAY: byte_count[CTR_APP_OUT]     += 64'(q.octets);
            KIND_IN_TCP:  byte_count[CTR_APP_IN_ALL]  += 64'(q.octets) + HDR_TCP;
            KIND_IN_UDP:  byte_count[CTR_APP_IN_ALL]  += 64'(q.octets) + HDR_UDP;
            KIND_OUT_TCP: byte_count[CTR_APP_OUT_ALL] += 64'(q.octets) + HDR_TCP;
            KIND_OUT_UDP: byte_count[CTR_APP_OUT_ALL] += 64'(q.octets) + HDR_UDP;
            KIND_OUT_RAW: byte_count[CTR_APP_OUT_ALL] += 64'(q.octets);
            KIND_SETUP:
            begin
                byte_count[CTR_APP_IN_ALL]  += HDR_TCP;
                byte_count[CTR_APP_OUT_ALL] += HDR_TCP;
            end
            KIND_SAMPLE:
                if (q.ok && m_full_ctrl)
                    adapter_sample(q.ain, q.aout);
            KIND_TICK:
            begin
                n_ticks++;
                predict_tick(q);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Driver: pops pending requests in bursts with random gaps between them.
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        request_t q;
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                kind <= q.kind;
                octets <= q.octets;
                time_ms <= q.time_ms;
                adapter_ok <= q.ok;
                adapter_in_octets <= q.ain;
                adapter_out_octets <= q.aout;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                // Some bursts run straight into the next one with no gap.
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: a pattern that changes mode now and then, and a long
    // hold-off on request, counted here so the block backs up onto its input.
    // ------------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 400);
                end
                mode_left--;
                case (stall_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= !out_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitors: accepted requests feed the predictor; accepted reports are
    // checked against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_request('{kind, octets, time_ms, adapter_ok,
                              adapter_in_octets, adapter_out_octets});
            n_taken++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            n_reports++;
            if (expected_reports.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("report with nothing expected: %p", seen);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (want != seen)
                begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        for (int i = 0; i < NUM_FIELDS; i++)
                            if (want[i] != seen[i])
                                $display("report %0d %s: expected %0d, got %0d",
                                         n_reports, field_name[i], want[i], seen[i]);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[traffic_rate_meter_limiter] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_request(logic [3:0] k, logic [31:0] oct, logic [31:0] t,
                                logic ok, logic [31:0] ain, logic [31:0] aout);
        pending_reqs.push_back('{k, oct, t, ok, ain, aout});
        n_pushed++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_MAX_DL:     m_max_dl = value;
            REG_WINDOW:     m_window = value;
            REG_RATE_SAMP:  m_rate_samples = value[9:0];
            REG_ACCEPT_SRC: m_accept_src = value[0];
            default:        m_full_ctrl = value[0];
        endcase
    endtask

    task automatic configure(logic [31:0] max_dl, logic [31:0] window,
                             logic [31:0] samples, logic accept_src, logic full_ctrl);
        write_reg(REG_MAX_DL, max_dl);
        write_reg(REG_WINDOW, window);
        write_reg(REG_RATE_SAMP, samples);
        write_reg(REG_ACCEPT_SRC, 32'(accept_src));
        write_reg(REG_FULL_CTRL, 32'(full_ctrl));
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every request went in and every report came out, then lets
    // a tick still in flight finish before the registers change.
    task automatic drain();
        while (n_taken != n_pushed || expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Random traffic: mostly accounting, about one tick in six, some adapter
    // samples and a few unknown kinds that the block ignores.
    task automatic add_random(int count, int oct_max);
        int          done_cnt;
        int          sel;
        logic [3:0]  k;
        logic [31:0] oct;
        logic [31:0] t;
        done_cnt = 0;
        while (done_cnt < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 16)
                k = KIND_TICK;
            else if (sel < 22)
                k = KIND_SAMPLE;
            else if (sel < 24)
                k = 4'(KIND_TICK + 1 + $urandom_range(0, 5));
            else
                k = 4'($urandom_range(KIND_IN_PAY, KIND_SETUP));
            if (k <= KIND_TICK)
                done_cnt++;

            case ($urandom_range(0, 11))
                0: oct = '1;
                1: oct = '0;
                2: oct = $urandom;
                default: oct = $urandom_range(0, oct_max);
            endcase

            case ($urandom_range(0, 9))
                0: begin gen_ain = $urandom; gen_aout = $urandom; end
                1: begin gen_ain -= $urandom_range(1, 500); gen_aout += 7; end
                default:
                begin
                    gen_ain += $urandom_range(0, 4 * oct_max);
                    gen_aout += $urandom_range(0, 4 * oct_max);
                end
            endcase

            if (k == KIND_TICK)
            begin
                case ($urandom_range(0, 24))
                    0: ;
                    1: gen_time = $urandom;
                    2: gen_time += $urandom_range(60000, 400000);
                    default: gen_time += $urandom_range(500, 1500);
                endcase
                t = gen_time;
            end
            else
                t = $urandom;
            push_request(k, oct, t, $urandom_range(0, 4) != 0, gen_ain, gen_aout);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings. Directed requests first: every kind, most at the field
        // extremes, a sample ignored without full control, an unknown kind,
        // a run of ticks with no time passing (so the limits stop on a zero
        // span), then a jump that trims all history, a wrap of the clock and
        // an adapter counter that goes down.
        push_request(KIND_IN_PAY, '1, '0, 1'b0, '0, '0);
        push_request(KIND_OUT_PAY, '1, '1, 1'b1, '1, '1);
        push_request(KIND_IN_TCP, '1, '0, 1'b0, '0, '0);
        push_request(KIND_IN_UDP, '0, '0, 1'b0, '0, '0);
        push_request(KIND_OUT_TCP, '1, '0, 1'b0, '0, '0);
        push_request(KIND_OUT_UDP, 32'd1000, '0, 1'b0, '0, '0);
        push_request(KIND_OUT_RAW, '1, '0, 1'b0, '0, '0);
        push_request(KIND_SETUP, '0, '0, 1'b0, '0, '0);
        push_request(KIND_SAMPLE, '0, '0, 1'b1, 32'd5000, 32'd6000);
        push_request(4'hF, '1, '1, 1'b1, '1, '1);
        for (int i = 0; i < 11; i++)
            push_request(KIND_TICK, 32'(i), 32'd5000, 1'b1, 32'(100 * i), 32'(50 * i));
        push_request(KIND_TICK, '0, 32'hFFFF_FFF0, 1'b1, '1, '1);
        push_request(KIND_TICK, '0, 32'h0000_0010, 1'b1, 32'd3, '1);
        gen_time = 32'h10;
        gen_ain = 32'd3;
        gen_aout = '1;
        add_random(150, 3000);
        drain();

        // Extremes: no ceiling, zero window, one sample back, forced limit off.
        configure('1, '0, 32'd1, 1'b1, 1'b1);
        add_random(80, 100000);
        drain();

        // Widest window and reach. The receiver holds off for a long stretch
        // while requests keep coming, so the block backs up onto its input.
        configure(32'd50000, '1, 32'd1023, 1'b0, 1'b1);
        add_random(150, 20000);
        hold_req++;
        drain();

        // Zero ceiling, no rates reported, only the forced limit active.
        configure('0, 32'd5000, 32'd0, 1'b0, 1'b0);
        add_random(80, 5000);
        drain();

        // Small traffic so the dynamic limit visits all its bands. Halfway,
        // the sender waits until every report is back.
        configure(32'd20000, 32'd30000, 32'd3, 1'b0, 1'b1);
        add_random(75, 4000);
        while (n_taken != n_pushed || expected_reports.size() != 0)
            @(negedge clk);
        add_random(75, 12000);
        drain();

        $display("covered %0d requests and %0d ticks over five register settings",
                 n_taken, n_ticks);
        $display("checked %0d reports, %0d mismatches", n_reports, n_mismatch);
        if (n_mismatch == 0 && expected_reports.size() == 0)
            $display("[traffic_rate_meter_limiter] OK");
        else
            $display("[traffic_rate_meter_limiter] ERROR");
        $finish;
    end

endmodule
